// ----- sv/lfp_pkg.sv -----
// shared types and constants of the led frame packer
`default_nettype none
package lfp_pkg;

  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 11;

  localparam logic [COUNT_W-1:0] FRAME_LENGTH_RESET = 11'd64;

  // register byte address of frame_length
  localparam logic [1:0] ADDR_FRAME_LENGTH = 2'd0;

  // command queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_LED     = 1'b0,
    KIND_SUMMARY = 1'b1
  } lfp_kind_e;

  // one classified pixel: which records it causes and their contents
  typedef struct packed {
    logic               emit_led;
    logic [COLOR_W-1:0] color;
    logic               emit_sum;
    logic               ok;
    logic [WORD_W-1:0]  checksum;
    logic [COUNT_W-1:0] lit;
    logic [WORD_W-1:0]  frames;
  } lfp_cmd_t;

  function automatic logic [WORD_W-1:0] pack_grb(input logic [COLOR_W-1:0] c);
    pack_grb = {c[15:8], c[23:16], c[7:0], 8'h00};
  endfunction

endpackage
`default_nettype wire

// ----- sv/lfp_front.sv -----
// front part: per-frame hashing, counting and pixel classification
`default_nettype none
module lfp_front #(
  parameter int unsigned MAX_PIXELS = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_valid_i,
  input  wire logic [lfp_pkg::COLOR_W-1:0]   color_i,
  input  wire logic                          eof_i,
  input  wire logic [lfp_pkg::COUNT_W-1:0]   frame_length_i,
  output logic                               cmd_valid_o,
  output lfp_pkg::lfp_cmd_t                  cmd_o
);

  logic [lfp_pkg::WORD_W-1:0]  hash_q, hash_d, hash_x, hash_m, hash_n;
  logic [lfp_pkg::COUNT_W-1:0] lit_q, lit_d, lit_n;
  logic [lfp_pkg::COUNT_W-1:0] pix_q, pix_d, pix_n;
  logic                        ovf_q, ovf_d, ovf_n;
  logic [lfp_pkg::WORD_W-1:0]  frames_q, frames_d, frames_n;
  logic                        pix_ok, frame_ok;

  always_comb begin
    pix_ok   = (pix_q < frame_length_i) && (32'(pix_q) < 32'(MAX_PIXELS));
    hash_x   = hash_q ^ {8'h00, color_i};
    hash_m   = hash_x * lfp_pkg::FNV_PRIME;
    hash_n   = pix_ok ? hash_m : hash_q;
    lit_n    = (pix_ok && (color_i != '0)) ? lit_q + 1'b1 : lit_q;
    pix_n    = pix_ok ? pix_q + 1'b1 : pix_q;
    ovf_n    = ovf_q | ~pix_ok;
    frame_ok = ~ovf_n && (pix_n == frame_length_i);
    frames_n = frame_ok ? frames_q + 1'b1 : frames_q;

    hash_d   = hash_q;
    lit_d    = lit_q;
    pix_d    = pix_q;
    ovf_d    = ovf_q;
    frames_d = frames_q;
    if (item_valid_i) begin
      if (eof_i) begin
        hash_d   = lfp_pkg::FNV_BASIS;
        lit_d    = '0;
        pix_d    = '0;
        ovf_d    = 1'b0;
        frames_d = frames_n;
      end else begin
        hash_d = hash_n;
        lit_d  = lit_n;
        pix_d  = pix_n;
        ovf_d  = ovf_n;
      end
    end

    cmd_valid_o     = item_valid_i && (pix_ok || eof_i);
    cmd_o.emit_led  = pix_ok;
    cmd_o.color     = color_i;
    cmd_o.emit_sum  = eof_i;
    cmd_o.ok        = frame_ok;
    cmd_o.checksum  = hash_n;
    cmd_o.lit       = lit_n;
    cmd_o.frames    = frames_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= lfp_pkg::FNV_BASIS;
      lit_q    <= '0;
      pix_q    <= '0;
      ovf_q    <= 1'b0;
      frames_q <= '0;
    end else begin
      hash_q   <= hash_d;
      lit_q    <= lit_d;
      pix_q    <= pix_d;
      ovf_q    <= ovf_d;
      frames_q <= frames_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lfp_queue.sv -----
// short command queue between front and back
`default_nettype none
module lfp_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_i,
  input  wire lfp_pkg::lfp_cmd_t wdata_i,
  output logic             full_o,
  input  wire logic        rd_i,
  output logic             empty_o,
  output lfp_pkg::lfp_cmd_t rdata_o
);

  lfp_pkg::lfp_cmd_t                 entry_q [lfp_pkg::QUEUE_DEPTH];
  logic [lfp_pkg::QPTR_W-1:0]        wptr_q, rptr_q;
  logic [lfp_pkg::QCNT_W-1:0]        cnt_q;
  logic                              do_wr, do_rd;

  assign full_o  = (cnt_q == lfp_pkg::QCNT_W'(lfp_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = entry_q[rptr_q];
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/lfp_back.sv -----
// back part: expands commands into led and summary records
`default_nettype none
module lfp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_empty_i,
  input  wire lfp_pkg::lfp_cmd_t           cmd_i,
  output logic                             cmd_rd_o,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output logic                             record_kind_o,
  output logic [lfp_pkg::WORD_W-1:0]       led_word_o,
  output logic                             frame_ok_o,
  output logic [lfp_pkg::WORD_W-1:0]       frame_checksum_o,
  output logic [lfp_pkg::COUNT_W-1:0]      lit_pixel_count_o,
  output logic [lfp_pkg::WORD_W-1:0]       frames_shown_o,
  output logic                             last_of_run_o
);

  logic                          out_valid_q, sum_pend_q;
  lfp_pkg::lfp_kind_e            kind_q;
  logic [lfp_pkg::WORD_W-1:0]    word_q;
  logic                          ok_q, last_q;
  logic [lfp_pkg::WORD_W-1:0]    sum_q;
  logic [lfp_pkg::COUNT_W-1:0]   lit_q;
  logic [lfp_pkg::WORD_W-1:0]    frames_q;
  // summary fields held while the led word of the same pixel waits
  logic                          p_ok_q;
  logic [lfp_pkg::WORD_W-1:0]    p_sum_q;
  logic [lfp_pkg::COUNT_W-1:0]   p_lit_q;
  logic [lfp_pkg::WORD_W-1:0]    p_frames_q;
  logic                          advance;

  assign advance  = ~out_valid_q | pop_i;
  assign cmd_rd_o = advance & ~sum_pend_q & ~cmd_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sum_pend_q  <= 1'b0;
    end else if (advance) begin
      if (sum_pend_q) begin
        out_valid_q <= 1'b1;
        sum_pend_q  <= 1'b0;
      end else if (!cmd_empty_i) begin
        out_valid_q <= 1'b1;
        sum_pend_q  <= cmd_i.emit_led & cmd_i.emit_sum;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (sum_pend_q) begin
        kind_q   <= lfp_pkg::KIND_SUMMARY;
        word_q   <= '0;
        ok_q     <= p_ok_q;
        sum_q    <= p_sum_q;
        lit_q    <= p_lit_q;
        frames_q <= p_frames_q;
        last_q   <= 1'b1;
      end else if (!cmd_empty_i) begin
        p_ok_q     <= cmd_i.ok;
        p_sum_q    <= cmd_i.checksum;
        p_lit_q    <= cmd_i.lit;
        p_frames_q <= cmd_i.frames;
        if (cmd_i.emit_led) begin
          kind_q   <= lfp_pkg::KIND_LED;
          word_q   <= lfp_pkg::pack_grb(cmd_i.color);
          ok_q     <= 1'b0;
          sum_q    <= '0;
          lit_q    <= '0;
          frames_q <= '0;
          last_q   <= ~cmd_i.emit_sum;
        end else begin
          kind_q   <= lfp_pkg::KIND_SUMMARY;
          word_q   <= '0;
          ok_q     <= cmd_i.ok;
          sum_q    <= cmd_i.checksum;
          lit_q    <= cmd_i.lit;
          frames_q <= cmd_i.frames;
          last_q   <= 1'b1;
        end
      end
    end
  end

  assign empty_o           = ~out_valid_q;
  assign record_kind_o     = kind_q;
  assign led_word_o        = word_q;
  assign frame_ok_o        = ok_q;
  assign frame_checksum_o  = sum_q;
  assign lit_pixel_count_o = lit_q;
  assign frames_shown_o    = frames_q;
  assign last_of_run_o     = last_q;

endmodule
`default_nettype wire

// ----- sv/led_frame_packer_with_checksum.sv -----
// top level of the ws2812 grb packer with frame checksum
`default_nettype none
// Takes one 0xRRGGBB pixel word per cycle while full is low and returns
// a G,R,B packed led word for every pixel kept, plus a summary word on
// the end-of-frame pixel carrying the fnv-1a style frame hash, the lit
// pixel count, a pass flag and the running count of good frames. Pixels
// past frame_length (or past MAX_PIXELS) are dropped and fail the frame.
// The hash loop is one constant 32x32 multiply and xor per cycle in the
// front part. The back part hands out one result word per cycle while pop
// keeps up, so an end-of-frame pixel that also yields a led word gives two
// result words; a four-entry command queue between the parts absorbs that
// and any back-pressure on pop. frame_length is written over the apb-style
// port at byte address 0; the user must write it only while the block is
// idle, and the block itself leaves this to the user.
module led_frame_packer_with_checksum #(
  parameter int unsigned MAX_PIXELS = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [1:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // pixel input
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [lfp_pkg::COLOR_W-1:0] pixel_color_i,
  input  wire logic                        end_of_frame_i,
  // result output
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             record_kind_o,
  output logic [lfp_pkg::WORD_W-1:0]       led_word_o,
  output logic                             frame_ok_o,
  output logic [lfp_pkg::WORD_W-1:0]       frame_checksum_o,
  output logic [lfp_pkg::COUNT_W-1:0]      lit_pixel_count_o,
  output logic [lfp_pkg::WORD_W-1:0]       frames_shown_o,
  output logic                             last_of_run_o
);

  logic [lfp_pkg::COUNT_W-1:0] frame_length_q;
  logic                        cfg_wr;
  logic                        item_valid;
  logic                        cmd_valid;
  lfp_pkg::lfp_cmd_t           cmd_in, cmd_out;
  logic                        q_full, q_empty, q_rd;

  // register file: a single length register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == lfp_pkg::ADDR_FRAME_LENGTH);
  assign prdata = (paddr == lfp_pkg::ADDR_FRAME_LENGTH)
                ? {{(32 - lfp_pkg::COUNT_W){1'b0}}, frame_length_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= lfp_pkg::FRAME_LENGTH_RESET;
    end else if (cfg_wr) begin
      frame_length_q <= pwdata[lfp_pkg::COUNT_W-1:0];
    end
  end

  // a pixel is taken whenever the queue has room, dropped pixels included
  assign full       = q_full;
  assign item_valid = push & ~q_full;

  lfp_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .color_i        (pixel_color_i),
    .eof_i          (end_of_frame_i),
    .frame_length_i (frame_length_q),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd_in)
  );

  lfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_valid),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (cmd_out)
  );

  // back part owns the output register and the pending summary
  lfp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_empty_i       (q_empty),
    .cmd_i             (cmd_out),
    .cmd_rd_o          (q_rd),
    .empty_o           (empty),
    .pop_i             (pop),
    .record_kind_o     (record_kind_o),
    .led_word_o        (led_word_o),
    .frame_ok_o        (frame_ok_o),
    .frame_checksum_o  (frame_checksum_o),
    .lit_pixel_count_o (lit_pixel_count_o),
    .frames_shown_o    (frames_shown_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule
`default_nettype wire
